// File: hdl/ildl_pkg.sv
// Shared types and constants for the indexed doubly linked list.
package ildl_pkg;

   localparam int ID_W       = 10;
   localparam int NODE_COUNT = 1023;
   localparam int MEM_DEPTH  = NODE_COUNT + 1;
   localparam int MEM_AW     = $clog2(MEM_DEPTH);

   typedef logic [ID_W-1:0] id_type;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_READ   = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_ID     = 2'd1,
      ST_ANCHOR = 2'd2,
      ST_EMPTY  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_LINK,
      S_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic clear_en;
      logic accept;
      logic exec;
      logic link;
      logic load_rsp;
   } ctl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_done;
      logic ins_ok;
      logic slot_free;
   } ctl_stat_type;

endpackage

// File: hdl/ildl_channels.sv
// Handshake channel interfaces for requests and responses.
interface ildl_req_if
   import ildl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   id_type     node_id;
   id_type     anchor_id;
   logic       place_after;

   modport source (output valid, cmd, node_id, anchor_id, place_after, input ready);
   modport sink   (input valid, cmd, node_id, anchor_id, place_after, output ready);
endinterface

interface ildl_rsp_if
   import ildl_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [1:0] status;
   id_type     read_id;
   logic       last;

   modport source (output valid, status, read_id, last, input ready);
   modport sink   (input valid, status, read_id, last, output ready);
endinterface

// File: hdl/ildl_ctrl.sv
// Sequencer for the clearing pass and the per-command steps.
module ildl_ctrl
   import ildl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  ctl_stat_type stat,
   output ctl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_FETCH;
         end
         S_FETCH: state_in = S_EXEC;
         S_EXEC: begin
            state_in = stat.ins_ok ? S_LINK : S_DONE;
         end
         S_LINK: state_in = S_DONE;
         S_DONE: begin
            if (stat.slot_free) state_in = S_IDLE;
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.clear_en = 1'b1;
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         S_EXEC:  cmd.exec = 1'b1;
         S_LINK:  cmd.link = 1'b1;
         S_DONE:  cmd.load_rsp = stat.slot_free;
         default: cmd = '0;
      endcase
   end

endmodule

// File: hdl/ildl_datapath.sv
// Link tables, membership bits, list pointers and response register.
module ildl_datapath
   import ildl_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  ctl_cmd_type  cmd,
   output ctl_stat_type stat,
   ildl_req_if.sink     req_ch,
   ildl_rsp_if.source   rsp_ch
);

   logic [ID_W-1:0] prev_mem   [MEM_DEPTH];
   logic [ID_W-1:0] next_mem   [MEM_DEPTH];
   logic            member_mem [MEM_DEPTH];

   cmd_type    op_ff;
   id_type     id_ff, anchor_ff;
   logic       after_ff;
   id_type     head_ff, head_in;
   id_type     tail_ff, tail_in;
   id_type     cursor_ff, cursor_in;
   id_type     left_ff, right_ff;
   logic [MEM_AW-1:0] clr_cnt_ff;

   id_type     prev_rd_ff, next_rd_ff;
   logic       mem_id_ff, mem_anchor_ff;

   status_type res_status_ff, res_status_in;
   id_type     res_id_ff, res_id_in;
   logic       res_last_ff, res_last_in;

   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   id_type     rsp_id_ff;
   logic       rsp_last_ff;

   id_type     cur_id, link_ra, left, right;
   logic       id_in_range, anchor_in_range, id_member, anchor_member, ins_ok;

   logic              prev_we, next_we, mem_we, mem_wd;
   logic [MEM_AW-1:0] prev_wa, next_wa, mem_wa;
   id_type            prev_wd, next_wd;

   // Hold the request fields for the whole command, and the neighbours found in the execute step.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= cmd_type'(req_ch.cmd);
         id_ff     <= req_ch.node_id;
         anchor_ff <= req_ch.anchor_id;
         after_ff  <= req_ch.place_after;
      end
      if (cmd.exec) begin
         left_ff  <= left;
         right_ff <= right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_ff + MEM_AW'(1);
      end
   end

   assign cur_id  = (cursor_ff != '0) ? cursor_ff : head_ff;
   assign link_ra = (op_ff == CMD_INSERT) ? anchor_ff :
                    (op_ff == CMD_REMOVE) ? id_ff : cur_id;

   // Memories: one write and registered reads per cycle.
   always_ff @(posedge clock) begin
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      if (next_we) next_mem[next_wa] <= next_wd;
      if (mem_we)  member_mem[mem_wa] <= mem_wd;
      prev_rd_ff    <= prev_mem[link_ra[MEM_AW-1:0]];
      next_rd_ff    <= next_mem[link_ra[MEM_AW-1:0]];
      mem_id_ff     <= member_mem[id_ff[MEM_AW-1:0]];
      mem_anchor_ff <= member_mem[anchor_ff[MEM_AW-1:0]];
   end

   assign id_in_range     = (id_ff != '0) &&
                            ({1'b0, id_ff} <= (ID_W+1)'(NODE_COUNT));
   assign anchor_in_range = (anchor_ff != '0) &&
                            ({1'b0, anchor_ff} <= (ID_W+1)'(NODE_COUNT));
   assign id_member       = id_in_range && mem_id_ff;
   assign anchor_member   = anchor_in_range && mem_anchor_ff;
   assign ins_ok          = (op_ff == CMD_INSERT) && id_in_range && !mem_id_ff &&
                            anchor_member;

   always_comb begin
      if (op_ff == CMD_INSERT) begin
         left  = after_ff ? anchor_ff : prev_rd_ff;
         right = after_ff ? next_rd_ff : anchor_ff;
      end else begin
         left  = prev_rd_ff;
         right = next_rd_ff;
      end
   end

   // Result, pointer updates and memory writes.
   always_comb begin
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      res_last_in   = res_last_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cursor_in     = cursor_ff;
      prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
      next_we = 1'b0; next_wa = '0; next_wd = '0;
      mem_we  = 1'b0; mem_wa  = '0; mem_wd  = 1'b0;

      if (cmd.clear_en) begin
         prev_we = 1'b1; prev_wa = clr_cnt_ff;
         next_we = 1'b1; next_wa = clr_cnt_ff;
         mem_we  = 1'b1; mem_wa  = clr_cnt_ff;
         mem_wd  = (clr_cnt_ff == MEM_AW'(1));
      end else if (cmd.exec) begin
         res_status_in = ST_OK;
         res_id_in     = '0;
         res_last_in   = 1'b0;
         case (op_ff)
            CMD_INSERT: begin
               if (!id_in_range || mem_id_ff) begin
                  res_status_in = ST_ID;
               end else if (!anchor_member) begin
                  res_status_in = ST_ANCHOR;
               end else begin
                  prev_we = 1'b1; prev_wa = id_ff[MEM_AW-1:0]; prev_wd = left;
                  next_we = 1'b1; next_wa = id_ff[MEM_AW-1:0]; next_wd = right;
                  mem_we  = 1'b1; mem_wa  = id_ff[MEM_AW-1:0]; mem_wd  = 1'b1;
               end
            end
            CMD_REMOVE: begin
               if (!id_member) begin
                  res_status_in = ST_ID;
               end else begin
                  if (left != '0) begin
                     next_we = 1'b1; next_wa = left[MEM_AW-1:0]; next_wd = right;
                  end else begin
                     head_in = right;
                  end
                  if (right != '0) begin
                     prev_we = 1'b1; prev_wa = right[MEM_AW-1:0]; prev_wd = left;
                  end else begin
                     tail_in = left;
                  end
                  mem_we = 1'b1; mem_wa = id_ff[MEM_AW-1:0]; mem_wd = 1'b0;
                  if (cursor_ff == id_ff) cursor_in = right;
               end
            end
            CMD_READ: begin
               if (head_ff == '0) begin
                  res_status_in = ST_EMPTY;
                  cursor_in     = '0;
               end else begin
                  res_id_in   = cur_id;
                  res_last_in = (next_rd_ff == '0);
                  cursor_in   = next_rd_ff;
               end
            end
            default: res_status_in = ST_OK;
         endcase
      end else if (cmd.link) begin
         if (left_ff != '0) begin
            next_we = 1'b1; next_wa = left_ff[MEM_AW-1:0]; next_wd = id_ff;
         end else begin
            head_in = id_ff;
         end
         if (right_ff != '0) begin
            prev_we = 1'b1; prev_wa = right_ff[MEM_AW-1:0]; prev_wd = id_ff;
         end else begin
            tail_in = id_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      res_last_ff   <= res_last_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_last_ff   <= res_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= ID_W'(1);
         tail_ff      <= ID_W'(1);
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         cursor_ff <= cursor_in;
         if (cmd.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.clear_done = (clr_cnt_ff == '1);
   assign stat.ins_ok     = ins_ok;
   assign stat.slot_free  = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = rsp_status_ff;
   assign rsp_ch.read_id = rsp_id_ff;
   assign rsp_ch.last    = rsp_last_ff;

endmodule

// File: hdl/indexed_doubly_linked_list.sv
// One transaction runs at a time: a request is taken only in the idle state. The steps are
//   set by the single write port on each link table (fetch, execute, optional relink, respond).
// Reset: synchronous; afterwards a clearing pass writes all 1024 table entries, one per
//   cycle, during which no request is taken. Node 1 is then the only member.
// A finished response waits in its own register while the next request is taken.
module indexed_doubly_linked_list
   import ildl_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ildl_req_if.sink   req_ch,
   ildl_rsp_if.source rsp_ch
);

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   // Controller: sequence the clearing pass and the fetch/execute/relink/respond steps.
   ildl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd)
   );

   // Datapath: link tables, membership bits, head/tail/cursor and the response register.
   ildl_datapath u_datapath (
      .clock  (clock),
      .reset  (reset),
      .cmd    (ctl_cmd),
      .stat   (ctl_stat),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

// File: tb/tb_indexed_doubly_linked_list.sv
// Self-checking testbench for the indexed doubly linked list, driven over its handshake channels.
module tb_indexed_doubly_linked_list;
   import ildl_pkg::*;

   // One response as the list should produce it.
   typedef struct packed {
      status_type status;
      id_type     read_id;
      logic       last;
   } list_reply_type;

   logic clock;
   logic reset;

   ildl_req_if req_ch ();
   ildl_rsp_if rsp_ch ();

   indexed_doubly_linked_list dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Shadow copy of the list: link tables, membership, head and read cursor.
   id_type link_prev [0:MEM_DEPTH-1];
   id_type link_next [0:MEM_DEPTH-1];
   logic   on_list   [0:MEM_DEPTH-1];
   id_type list_head;
   id_type read_cursor;

   // Ids currently on the list, kept so stimulus can pick members quickly.
   id_type live_ids [$];

   // Responses still owed by the block, oldest first.
   list_reply_type pending_replies [$];

   int unsigned mismatch_count;
   int unsigned req_calm;

   // Run the clock: period of 10 units.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run well beyond the slowest legal schedule, clearing pass included.
   initial begin
      #2000000;
      $display("tb_indexed_doubly_linked_list NOT OK");
      $finish;
   end

   function automatic logic is_listed(id_type id);
      return id != '0 && int'(id) <= NODE_COUNT && on_list[id];
   endfunction

   // Apply one command to the shadow list and return the response it must produce.
   function automatic list_reply_type apply_list_op(cmd_type op, id_type id, id_type anchor,
                                                    logic place_after);
      list_reply_type reply;
      id_type         left;
      id_type         right;
      id_type         at;
      reply.status  = ST_OK;
      reply.read_id = '0;
      reply.last    = 1'b0;
      case (op)
         CMD_INSERT: begin
            // Check the new id first, then the anchor.
            if (id == '0 || int'(id) > NODE_COUNT || on_list[id]) begin
               reply.status = ST_ID;
            end else if (!is_listed(anchor)) begin
               reply.status = ST_ANCHOR;
            end else begin
               left  = place_after ? anchor : link_prev[anchor];
               right = place_after ? link_next[anchor] : anchor;
               link_prev[id] = left;
               link_next[id] = right;
               if (left != '0) link_next[left] = id;
               else list_head = id;
               if (right != '0) link_prev[right] = id;
               on_list[id] = 1'b1;
               live_ids = {live_ids, id};
            end
         end
         CMD_REMOVE: begin
            if (!is_listed(id)) begin
               reply.status = ST_ID;
            end else begin
               left  = link_prev[id];
               right = link_next[id];
               if (left != '0) link_next[left] = right;
               else list_head = right;
               if (right != '0) link_prev[right] = left;
               // Removing the cursor id moves the cursor on to its successor.
               if (read_cursor == id) read_cursor = right;
               link_prev[id] = '0;
               link_next[id] = '0;
               on_list[id]   = 1'b0;
               for (int i = 0; i < live_ids.size(); i++) begin
                  if (live_ids[i] == id) begin
                     live_ids.delete(i);
                     break;
                  end
               end
            end
         end
         CMD_READ: begin
            if (list_head == '0) begin
               reply.status = ST_EMPTY;
               read_cursor  = '0;
            end else begin
               at = is_listed(read_cursor) ? read_cursor : list_head;
               reply.read_id = at;
               read_cursor   = link_next[at];
               reply.last    = (read_cursor == '0);
            end
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   // Draw an idle count from 0 to 7, with occasional stretches of no idling at all.
   function automatic int unsigned draw_wait(inout int unsigned calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, 7);
   endfunction

   function automatic id_type pick_member();
      if (live_ids.size() == 0) return id_type'($urandom);
      return live_ids[$urandom_range(0, live_ids.size() - 1)];
   endfunction

   function automatic id_type pick_stranger();
      id_type id;
      do id = id_type'($urandom); while (is_listed(id));
      return id;
   endfunction

   // Offer one transaction after a random gap; record its expected response once taken.
   // Keep valid high across back-to-back transactions so it gets one assignment per edge.
   task automatic send_item(cmd_type op, id_type id, id_type anchor, logic place_after);
      int unsigned    gap;
      list_reply_type reply;
      gap = draw_wait(req_calm);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.cmd         <= op;
      req_ch.node_id     <= id;
      req_ch.anchor_id   <= anchor;
      req_ch.place_after <= place_after;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      reply = apply_list_op(op, id, anchor, place_after);
      pending_replies = {pending_replies, reply};
   endtask

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   // Take responses with random back-pressure and compare each with the oldest expectation.
   initial begin : response_checker
      int unsigned    hold;
      int unsigned    calm;
      list_reply_type want;
      calm = 0;
      hold = draw_wait(calm);
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_replies.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual status %0d id %0d last %0d",
                        $time, rsp_ch.status, rsp_ch.read_id, rsp_ch.last);
               mismatch_count++;
            end else begin
               want = pending_replies.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("read_id", want.read_id, rsp_ch.read_id);
               check_field("last", want.last, rsp_ch.last);
            end
            hold = draw_wait(calm);
         end
         if (hold > 0) begin
            rsp_ch.ready <= 1'b0;
            hold--;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // Fresh list: node 1 alone, so reads return it as the tail each time.
   task automatic test_reset_state();
      send_item(CMD_READ, '0, '0, 1'b0);
      send_item(CMD_READ, id_type'(1023), id_type'(1023), 1'b1);
      send_item(CMD_NOP, id_type'(1023), id_type'(1023), 1'b1);
   endtask

   // Bad ids, duplicates, a tail insert and absent anchors first, then insert at head, tail and middle.
   task automatic test_insert_cases();
      send_item(CMD_INSERT, '0, id_type'(1), 1'b1);
      send_item(CMD_INSERT, id_type'(1), id_type'(1), 1'b0);
      send_item(CMD_INSERT, id_type'(1023), id_type'(1), 1'b1);
      send_item(CMD_INSERT, id_type'(2), '0, 1'b1);
      send_item(CMD_INSERT, id_type'(2), id_type'(700), 1'b0);
      send_item(CMD_INSERT, id_type'(512), id_type'(1), 1'b0);
      send_item(CMD_INSERT, id_type'(341), id_type'(1023), 1'b1);
      send_item(CMD_INSERT, id_type'(682), id_type'(1023), 1'b0);
   endtask

   // Walk past the tail so the cursor wraps to the head.
   task automatic test_read_walk();
      repeat (6) send_item(CMD_READ, id_type'($urandom), id_type'($urandom), 1'b0);
   endtask

   // Absent removes, then remove the cursor id, the cursor at the tail, and the head.
   task automatic test_remove_cases();
      send_item(CMD_REMOVE, '0, '0, 1'b0);
      send_item(CMD_REMOVE, id_type'(700), id_type'(1023), 1'b1);
      send_item(CMD_REMOVE, read_cursor, '0, 1'b0);
      send_item(CMD_READ, '0, '0, 1'b0);
      send_item(CMD_READ, '0, '0, 1'b0);
      send_item(CMD_REMOVE, read_cursor, '0, 1'b0);
      send_item(CMD_READ, '0, '0, 1'b0);
      send_item(CMD_REMOVE, list_head, '0, 1'b0);
   endtask

   // One random transaction, steering the list size toward target. Most are well formed;
   // the rest are noise or deliberately broken. Never let the list run empty here.
   task automatic random_item(int unsigned target, int unsigned read_pct);
      int unsigned roll;
      cmd_type     op;
      id_type      id;
      logic        place_after;
      roll        = $urandom_range(0, 99);
      place_after = 1'($urandom_range(0, 1));
      if (roll < read_pct) begin
         send_item(CMD_READ, id_type'($urandom), id_type'($urandom), place_after);
      end else if (roll < read_pct + 8) begin
         op = cmd_type'($urandom_range(0, 3));
         id = id_type'($urandom);
         if (op == CMD_REMOVE && live_ids.size() == 1 && is_listed(id)) op = CMD_READ;
         send_item(op, id, id_type'($urandom), place_after);
      end else if (roll < read_pct + 12) begin
         case ($urandom_range(0, 2))
            0: send_item(CMD_INSERT, pick_member(), pick_member(), place_after);
            1: send_item(CMD_INSERT, pick_stranger(), pick_stranger(), place_after);
            default: send_item(CMD_REMOVE, pick_stranger(), pick_member(), place_after);
         endcase
      end else if (roll < read_pct + 16 && is_listed(read_cursor) && live_ids.size() > 1) begin
         send_item(CMD_REMOVE, read_cursor, id_type'($urandom), place_after);
      end else if (live_ids.size() < target || live_ids.size() <= 1) begin
         send_item(CMD_INSERT, pick_stranger(), pick_member(), place_after);
      end else begin
         send_item(CMD_REMOVE, pick_member(), id_type'($urandom), place_after);
      end
   endtask

   // Build a long list.
   task automatic test_random_growth();
      repeat (350) random_item(160, 20);
   endtask

   // Hold the list short and read a lot, so the walk wraps often.
   task automatic test_random_churn();
      int unsigned target;
      target = 8;
      for (int i = 0; i < 750; i++) begin
         if (i % 50 == 0) target = $urandom_range(1, 24);
         random_item(target, 35);
      end
   endtask

   // Shrink to one or two members and work the single-node cases.
   task automatic test_random_shrink();
      repeat (350) random_item(1, 25);
   endtask

   // Empty the list; from here on reads report empty and every insert lacks an anchor.
   task automatic test_empty_list();
      while (live_ids.size() > 0) send_item(CMD_REMOVE, live_ids[0], id_type'($urandom), 1'b0);
      send_item(CMD_READ, '0, '0, 1'b0);
      send_item(CMD_READ, id_type'(1023), id_type'(1023), 1'b1);
      send_item(CMD_INSERT, id_type'(5), id_type'(1), 1'b1);
      send_item(CMD_INSERT, id_type'(1), id_type'(1), 1'b0);
      send_item(CMD_REMOVE, id_type'(1), '0, 1'b0);
      send_item(CMD_NOP, id_type'($urandom), id_type'($urandom), 1'b1);
      send_item(CMD_READ, '0, '0, 1'b0);
   endtask

   initial begin
      mismatch_count = 0;
      req_calm       = 0;
      for (int i = 0; i < MEM_DEPTH; i++) begin
         link_prev[i] = '0;
         link_next[i] = '0;
         on_list[i]   = 1'b0;
      end
      on_list[1]  = 1'b1;
      list_head   = id_type'(1);
      read_cursor = '0;
      live_ids    = {live_ids, id_type'(1)};

      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.cmd         <= CMD_NOP;
      req_ch.node_id     <= '0;
      req_ch.anchor_id   <= '0;
      req_ch.place_after <= 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // The clearing pass after reset holds ready low; the first send simply waits it out.
      test_reset_state();
      test_insert_cases();
      test_read_walk();
      test_remove_cases();
      test_random_growth();
      test_random_churn();
      test_random_shrink();
      test_empty_list();
      req_ch.valid <= 1'b0;

      // Drain outstanding responses, then allow a few more cycles for strays.
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("tb_indexed_doubly_linked_list OK");
      end else begin
         $display("tb_indexed_doubly_linked_list NOT OK");
      end
      $finish;
   end

endmodule

// File: indexed_doubly_linked_list.f
hdl/ildl_pkg.sv
hdl/ildl_channels.sv
hdl/ildl_ctrl.sv
hdl/ildl_datapath.sv
hdl/indexed_doubly_linked_list.sv
tb/tb_indexed_doubly_linked_list.sv
